// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cdt_pkg.sv
// types and constants for the countdown timer with progress
`timescale 1ns / 1ps

package cdt_pkg;

    localparam int TICKS_PER_SECOND = 100;
    localparam int LOOP_SECONDS     = 60;
    localparam int COLOUR_MAX       = 255;
    localparam int PCT_MAX          = 100;

    localparam int SEC_W = 16;
    localparam int PCT_W = 7;
    localparam int COL_W = 8;
    localparam int TT_W  = 23;
    localparam int PRE_W = 7;
    localparam int MOD_W = $clog2(LOOP_SECONDS);

    localparam logic [TT_W-1:0] TT_MAX = {TT_W{1'b1}};

    // shared divider: quotient bits and datapath width
    localparam int QW    = 11;
    localparam int CNT_W = $clog2(QW);
    localparam int DW    = 33;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_PAUSE = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [SEC_W-1:0] start_seconds;
    } t_in_item;

    typedef struct packed {
        logic [SEC_W-1:0] seconds_now;
        logic [PCT_W-1:0] percent;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic             show_event;
        logic             colour_event;
        logic             finish_event;
        logic             random_colour_request;
    } t_out_item;

endpackage

// File: rtl/countdown_timer_with_progress_core.sv
// seconds timer with colour fade and progress percent, one shared divider
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_stall       i_in_data  (cdt_pkg::t_in_item)
//  out       output     o_out_valid / i_out_stall     o_out_data (cdt_pkg::t_out_item)
//  cfg       input      i_cfg_we                      i_cfg_wdata (count-up mode)
//
// a running count-down tick runs the 11-step restoring divider once for the colour and
// once for the percent, another count-down item once for the percent, a count-up item runs it twice
// for the loop remainder and its scaling, and a zero start value skips it
// o_in_stall is high from accept until the result is placed in the output register
// the next transaction is taken while a finished result waits on i_out_stall
// synchronous active-low reset clears the timer state, colour and mode
`timescale 1ns / 1ps

module countdown_timer_with_progress_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cdt_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cdt_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PCT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_COLOUR,
        PH_PCT_DOWN,
        PH_MOD,
        PH_SCALE
    } t_phase;

    // control state
    t_state                       r_state, n_state;
    t_phase                       r_phase, n_phase;
    logic                         r_mode, n_mode;
    logic                         r_run, n_run;
    logic [cdt_pkg::SEC_W-1:0]    r_sc, n_sc;
    logic [cdt_pkg::SEC_W-1:0]    r_sv, n_sv;
    logic [cdt_pkg::TT_W-1:0]     r_tt, n_tt;
    logic [cdt_pkg::PRE_W-1:0]    r_pre, n_pre;
    logic [cdt_pkg::COL_W-1:0]    r_red, n_red;
    logic [cdt_pkg::COL_W-1:0]    r_green, n_green;
    logic                         r_ov, n_ov;
    logic [cdt_pkg::CNT_W-1:0]    r_cnt, n_cnt;

    // payload
    logic [cdt_pkg::DW-1:0]       r_rem, n_rem;
    logic [cdt_pkg::DW-1:0]       r_dsh, n_dsh;
    logic [cdt_pkg::QW-1:0]       r_q, n_q;
    logic [cdt_pkg::PCT_W-1:0]    r_pct, n_pct;
    logic                         r_neg, n_neg;
    logic                         r_show, n_show;
    logic                         r_col, n_col;
    logic                         r_fin, n_fin;
    logic                         r_rnd, n_rnd;
    cdt_pkg::t_out_item           r_out, n_out;

    logic                         in_acc;
    logic [cdt_pkg::TT_W-1:0]     w_span;
    logic [cdt_pkg::TT_W-1:0]     w_tt_inc;
    logic [cdt_pkg::TT_W-1:0]     w_t;
    logic [cdt_pkg::DW-1:0]       w_col_num;
    logic [cdt_pkg::PRE_W-1:0]    w_pre_inc;
    logic [cdt_pkg::SEC_W-1:0]    w_sc_sec;
    logic                         w_ge;
    logic [cdt_pkg::DW-1:0]       w_rem_step;
    logic [cdt_pkg::QW-1:0]       w_q_step;
    logic [cdt_pkg::MOD_W-1:0]    w_mod_raw;
    logic [cdt_pkg::MOD_W-1:0]    w_mod_fix;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    assign w_span    = cdt_pkg::TT_W'(r_sv) * cdt_pkg::TT_W'(cdt_pkg::TICKS_PER_SECOND);
    assign w_tt_inc  = (r_tt < cdt_pkg::TT_MAX) ? r_tt + cdt_pkg::TT_W'(1) : r_tt;
    assign w_t       = (w_tt_inc > w_span) ? w_span : w_tt_inc;
    assign w_col_num = cdt_pkg::DW'(w_t) * cdt_pkg::DW'(cdt_pkg::COLOUR_MAX);
    assign w_pre_inc = r_pre + cdt_pkg::PRE_W'(1);

    // second update: count-up saturates at max, count-down at zero
    assign w_sc_sec = r_mode ? ((r_sc != {cdt_pkg::SEC_W{1'b1}}) ?
                                r_sc + cdt_pkg::SEC_W'(1) : r_sc)
                             : ((r_sc != '0) ? r_sc - cdt_pkg::SEC_W'(1) : r_sc);

    // one restoring step of the shared divider
    assign w_ge       = (r_rem >= r_dsh);
    assign w_rem_step = w_ge ? r_rem - r_dsh : r_rem;
    assign w_q_step   = {r_q[cdt_pkg::QW-2:0], w_ge};

    // floor modulo for a negative difference
    assign w_mod_raw = w_rem_step[cdt_pkg::MOD_W-1:0];
    assign w_mod_fix = (r_neg && (w_mod_raw != '0)) ?
                       cdt_pkg::MOD_W'(cdt_pkg::LOOP_SECONDS) - w_mod_raw : w_mod_raw;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_mode  = r_mode;
        n_run   = r_run;
        n_sc    = r_sc;
        n_sv    = r_sv;
        n_tt    = r_tt;
        n_pre   = r_pre;
        n_red   = r_red;
        n_green = r_green;
        n_ov    = r_ov;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_pct   = r_pct;
        n_neg   = r_neg;
        n_show  = r_show;
        n_col   = r_col;
        n_fin   = r_fin;
        n_rnd   = r_rnd;
        n_out   = r_out;

        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
        end

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_show  = 1'b0;
                    n_col   = 1'b0;
                    n_fin   = 1'b0;
                    n_rnd   = 1'b0;
                    n_state = S_PCT;
                    case (i_in_data.cmd)
                        cdt_pkg::CMD_START: begin
                            if (r_sc == '0) begin
                                n_sv = i_in_data.start_seconds;
                                n_sc = i_in_data.start_seconds;
                                if (r_mode) begin
                                    n_rnd = 1'b1;
                                end else begin
                                    n_red   = '0;
                                    n_green = cdt_pkg::COL_W'(cdt_pkg::COLOUR_MAX);
                                end
                            end
                            n_show = 1'b1;
                            n_run  = 1'b1;
                        end
                        cdt_pkg::CMD_PAUSE: begin
                            n_run = 1'b0;
                        end
                        cdt_pkg::CMD_RESET: begin
                            n_run  = 1'b0;
                            n_sc   = '0;
                            n_sv   = '0;
                            n_tt   = '0;
                            n_pre  = '0;
                            n_show = 1'b1;
                        end
                        cdt_pkg::CMD_TICK: begin
                            // count-down with no start value stays frozen
                            if (r_run && !(!r_mode && (r_sv == '0))) begin
                                n_tt  = w_tt_inc;
                                n_pre = w_pre_inc;
                                if (!r_mode) begin
                                    n_col   = 1'b1;
                                    n_rem   = w_col_num;
                                    n_dsh   = cdt_pkg::DW'(w_span) << (cdt_pkg::QW - 1);
                                    n_cnt   = cdt_pkg::CNT_W'(cdt_pkg::QW - 1);
                                    n_phase = PH_COLOUR;
                                    n_state = S_DIV;
                                end
                                if (w_pre_inc >= cdt_pkg::PRE_W'(cdt_pkg::TICKS_PER_SECOND)) begin
                                    n_pre  = w_pre_inc
                                           - cdt_pkg::PRE_W'(cdt_pkg::TICKS_PER_SECOND);
                                    n_sc   = w_sc_sec;
                                    n_rnd  = r_mode;
                                    n_show = 1'b1;
                                    if (w_sc_sec == '0) begin
                                        n_run = 1'b0;
                                        n_sv  = '0;
                                        n_tt  = '0;
                                        n_pre = '0;
                                        n_fin = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_run = r_run;
                        end
                    endcase
                end
            end

            S_PCT: begin
                if (r_sv == '0) begin
                    n_pct   = '0;
                    n_state = S_DONE;
                end else if (r_mode) begin
                    n_neg   = (r_sc < r_sv);
                    n_rem   = cdt_pkg::DW'((r_sc >= r_sv) ? r_sc - r_sv : r_sv - r_sc);
                    n_dsh   = cdt_pkg::DW'(cdt_pkg::LOOP_SECONDS) << (cdt_pkg::QW - 1);
                    n_cnt   = cdt_pkg::CNT_W'(cdt_pkg::QW - 1);
                    n_phase = PH_MOD;
                    n_state = S_DIV;
                end else begin
                    n_rem   = cdt_pkg::DW'(r_sc) * cdt_pkg::DW'(cdt_pkg::PCT_MAX);
                    n_dsh   = cdt_pkg::DW'(r_sv) << (cdt_pkg::QW - 1);
                    n_cnt   = cdt_pkg::CNT_W'(cdt_pkg::QW - 1);
                    n_phase = PH_PCT_DOWN;
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                n_rem = w_rem_step;
                n_q   = w_q_step;
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - cdt_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    case (r_phase)
                        PH_COLOUR: begin
                            // green is 255 minus red, one less when the ratio is inexact
                            n_red   = w_q_step[cdt_pkg::COL_W-1:0];
                            n_green = (w_rem_step == '0) ?
                                      cdt_pkg::COL_W'(cdt_pkg::COLOUR_MAX)
                                      - w_q_step[cdt_pkg::COL_W-1:0] :
                                      cdt_pkg::COL_W'(cdt_pkg::COLOUR_MAX - 1)
                                      - w_q_step[cdt_pkg::COL_W-1:0];
                            n_state = S_PCT;
                        end
                        PH_PCT_DOWN: begin
                            // a saturated quotient is above 100 as well
                            n_pct   = (w_q_step > cdt_pkg::QW'(cdt_pkg::PCT_MAX)) ?
                                      cdt_pkg::PCT_W'(cdt_pkg::PCT_MAX) :
                                      w_q_step[cdt_pkg::PCT_W-1:0];
                            n_state = S_DONE;
                        end
                        PH_MOD: begin
                            n_rem   = cdt_pkg::DW'(w_mod_fix) * cdt_pkg::DW'(cdt_pkg::PCT_MAX);
                            n_dsh   = cdt_pkg::DW'(cdt_pkg::LOOP_SECONDS) << (cdt_pkg::QW - 1);
                            n_cnt   = cdt_pkg::CNT_W'(cdt_pkg::QW - 1);
                            n_phase = PH_SCALE;
                        end
                        PH_SCALE: begin
                            n_pct   = w_q_step[cdt_pkg::PCT_W-1:0];
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_out.seconds_now           = r_sc;
                    n_out.percent               = r_pct;
                    n_out.red                   = r_red;
                    n_out.green                 = r_green;
                    n_out.blue                  = '0;
                    n_out.show_event            = r_show;
                    n_out.colour_event          = r_col;
                    n_out.finish_event          = r_fin;
                    n_out.random_colour_request = r_rnd;
                    n_ov                        = 1'b1;
                    n_state                     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_COLOUR;
            r_mode  <= 1'b0;
            r_run   <= 1'b0;
            r_sc    <= '0;
            r_sv    <= '0;
            r_tt    <= '0;
            r_pre   <= '0;
            r_red   <= '0;
            r_green <= '0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_run   <= n_run;
            r_sc    <= n_sc;
            r_sv    <= n_sv;
            r_tt    <= n_tt;
            r_pre   <= n_pre;
            r_red   <= n_red;
            r_green <= n_green;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_pct  <= n_pct;
        r_neg  <= n_neg;
        r_show <= n_show;
        r_col  <= n_col;
        r_fin  <= n_fin;
        r_rnd  <= n_rnd;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// File: rtl/cdt_checker.sv
// port-level checks for the countdown timer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cdt_pkg::t_out_item o_out_data
);

    logic       w_out_held;
    logic       w_in_acc;
    logic       w_pct_ok;
    logic       w_fin_shown;
    logic       w_fin_ok;
    logic       w_fade_shown;
    logic [8:0] w_col_sum;
    logic       w_fade_ok;

    assign w_out_held   = o_out_valid && i_out_stall;
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_pct_ok     = (o_out_data.percent <= 7'd100);
    assign w_fin_shown  = o_out_valid && o_out_data.finish_event;
    assign w_fin_ok     = (o_out_data.seconds_now == 16'd0) && o_out_data.show_event;
    assign w_fade_shown = o_out_valid && o_out_data.colour_event;
    assign w_col_sum    = 9'(o_out_data.red) + 9'(o_out_data.green);
    assign w_fade_ok    = (w_col_sum == 9'd255) || (w_col_sum == 9'd254);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_out_valid, "stalled result dropped")

    // one transaction at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, w_in_acc, o_in_stall, "input taken while busy")

    `ASSERT_HOLDS(a_pct_range, i_clk, i_rst_n, o_out_valid |-> w_pct_ok, "percent above 100")

    // finish clears the count and refreshes the display
    `ASSERT_HOLDS(a_finish, i_clk, i_rst_n, w_fin_shown |-> w_fin_ok, "finish with nonzero count")

    // faded colour sums to 255 or one less
    `ASSERT_HOLDS(a_fade_sum, i_clk, i_rst_n, w_fade_shown |-> w_fade_ok, "fade out of balance")

endmodule

bind countdown_timer_with_progress_core cdt_checker u_cdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/countdown_timer_with_progress_core_tb.sv
// self-checking testbench for the countdown timer with progress and colour fade
`timescale 1ns / 1ps

module countdown_timer_with_progress_core_tb;

    // tracks the timer state and holds the readings the block owes us
    class timer_tracker;
        bit                        up_mode;
        bit                        running;
        logic [cdt_pkg::SEC_W-1:0] seconds;
        logic [cdt_pkg::SEC_W-1:0] loaded;
        logic [cdt_pkg::TT_W-1:0]  ticks_seen;
        logic [cdt_pkg::PRE_W-1:0] prescale;
        logic [cdt_pkg::COL_W-1:0] red;
        logic [cdt_pkg::COL_W-1:0] green;
        cdt_pkg::t_out_item        expected_readings[$];
        int                        errors;

        function new();
            up_mode = 1'b0;
            red     = '0;
            green   = '0;
            errors  = 0;
            stop_and_clear();
        endfunction

        function void set_mode(bit m);
            up_mode = m;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void stop_and_clear();
            running    = 1'b0;
            seconds    = '0;
            loaded     = '0;
            ticks_seen = '0;
            prescale   = '0;
        endfunction

        function logic [cdt_pkg::PCT_W-1:0] progress();
            int sc;
            int sv;
            int rem;
            int neg;
            int p;
            sc = int'(seconds);
            sv = int'(loaded);
            if (sv == 0) begin
                return '0;
            end
            if (up_mode) begin
                // floor modulo of the distance from the loaded value
                if (sc >= sv) begin
                    rem = (sc - sv) % cdt_pkg::LOOP_SECONDS;
                end else begin
                    neg = (sv - sc) % cdt_pkg::LOOP_SECONDS;
                    rem = (neg == 0) ? 0 : cdt_pkg::LOOP_SECONDS - neg;
                end
                return cdt_pkg::PCT_W'((rem * cdt_pkg::PCT_MAX) / cdt_pkg::LOOP_SECONDS);
            end
            p = (sc * cdt_pkg::PCT_MAX) / sv;
            return cdt_pkg::PCT_W'((p > cdt_pkg::PCT_MAX) ? cdt_pkg::PCT_MAX : p);
        endfunction

        function void note_command(cdt_pkg::t_in_item it);
            cdt_pkg::t_out_item r;
            longint             span;
            longint             t;
            bit                 show;
            bit                 fade;
            bit                 done;
            bit                 rnd;
            show = 1'b0;
            fade = 1'b0;
            done = 1'b0;
            rnd  = 1'b0;
            case (it.cmd)
                cdt_pkg::CMD_START: begin
                    if (seconds == 0) begin
                        loaded  = it.start_seconds;
                        seconds = it.start_seconds;
                        if (up_mode) begin
                            rnd = 1'b1;
                        end else begin
                            red   = '0;
                            green = cdt_pkg::COL_W'(cdt_pkg::COLOUR_MAX);
                        end
                    end
                    show    = 1'b1;
                    running = 1'b1;
                end
                cdt_pkg::CMD_PAUSE: begin
                    running = 1'b0;
                end
                cdt_pkg::CMD_RESET: begin
                    stop_and_clear();
                    show = 1'b1;
                end
                default: begin
                    // count-down with nothing loaded keeps everything frozen
                    if (running && !(!up_mode && loaded == 0)) begin
                        if (ticks_seen != cdt_pkg::TT_MAX) begin
                            ticks_seen++;
                        end
                        prescale++;
                        if (!up_mode) begin
                            span  = longint'(loaded) * cdt_pkg::TICKS_PER_SECOND;
                            t     = (longint'(ticks_seen) > span) ? span : longint'(ticks_seen);
                            red   = cdt_pkg::COL_W'((cdt_pkg::COLOUR_MAX * t) / span);
                            green = cdt_pkg::COL_W'((cdt_pkg::COLOUR_MAX * (span - t)) / span);
                            fade  = 1'b1;
                        end
                        if (prescale >= cdt_pkg::PRE_W'(cdt_pkg::TICKS_PER_SECOND)) begin
                            prescale -= cdt_pkg::PRE_W'(cdt_pkg::TICKS_PER_SECOND);
                            if (up_mode) begin
                                if (seconds != '1) begin
                                    seconds++;
                                end
                                rnd = 1'b1;
                            end else if (seconds != 0) begin
                                seconds--;
                            end
                            show = 1'b1;
                            if (seconds == 0) begin
                                stop_and_clear();
                                done = 1'b1;
                            end
                        end
                    end
                end
            endcase
            r.seconds_now           = seconds;
            r.percent               = progress();
            r.red                   = red;
            r.green                 = green;
            r.blue                  = '0;
            r.show_event            = show;
            r.colour_event          = fade;
            r.finish_event          = done;
            r.random_colour_request = rnd;
            expected_readings.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_reading(cdt_pkg::t_out_item got);
            cdt_pkg::t_out_item want;
            if (expected_readings.size() == 0) begin
                $error("output transaction with no pending expectation");
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            compare("seconds_now", 32'(want.seconds_now), 32'(got.seconds_now));
            compare("percent", 32'(want.percent), 32'(got.percent));
            compare("red", 32'(want.red), 32'(got.red));
            compare("green", 32'(want.green), 32'(got.green));
            compare("blue", 32'(want.blue), 32'(got.blue));
            compare("show_event", 32'(want.show_event), 32'(got.show_event));
            compare("colour_event", 32'(want.colour_event), 32'(got.colour_event));
            compare("finish_event", 32'(want.finish_event), 32'(got.finish_event));
            compare("random_colour_request", 32'(want.random_colour_request),
                    32'(got.random_colour_request));
        endfunction
    endclass

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    cdt_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    cdt_pkg::t_out_item out_data;
    logic               cfg_we    = 1'b0;
    logic               cfg_wdata = 1'b0;

    timer_tracker      tracker;
    cdt_pkg::t_in_item stim_q[$];
    bit                quiet = 1'b0;

    countdown_timer_with_progress_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [cdt_pkg::SEC_W-1:0] any_secs();
        return cdt_pkg::SEC_W'($urandom_range(0, 65535));
    endfunction

    // small values so count-down finishes are reachable, plus the extremes
    function automatic logic [cdt_pkg::SEC_W-1:0] start_secs();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return cdt_pkg::SEC_W'($urandom_range(1, 3));
        end
        if (r < 70) begin
            return '0;
        end
        if (r < 80) begin
            return cdt_pkg::SEC_W'(16'hFFFF - $urandom_range(0, 1));
        end
        if (r < 88) begin
            return cdt_pkg::SEC_W'($urandom_range(4, 70));
        end
        return any_secs();
    endfunction

    function automatic void push(cdt_pkg::t_cmd c, logic [cdt_pkg::SEC_W-1:0] s);
        cdt_pkg::t_in_item it;
        it.cmd           = c;
        it.start_seconds = s;
        stim_q.push_back(it);
    endfunction

    function automatic void load_directed_down();
        push(cdt_pkg::CMD_TICK, 16'hFFFF);   // tick while stopped
        push(cdt_pkg::CMD_START, 16'h0000);  // zero start value
        push(cdt_pkg::CMD_TICK, 16'h0000);   // frozen tick
        push(cdt_pkg::CMD_PAUSE, 16'hFFFF);
        push(cdt_pkg::CMD_RESET, 16'hAAAA);
        push(cdt_pkg::CMD_START, 16'd2);
        push(cdt_pkg::CMD_TICK, 16'h5555);
        push(cdt_pkg::CMD_TICK, 16'hAAAA);
        push(cdt_pkg::CMD_START, 16'h5555);  // nonzero count, no reload
        push(cdt_pkg::CMD_PAUSE, 16'h0000);
        push(cdt_pkg::CMD_TICK, 16'hFFFF);
        push(cdt_pkg::CMD_START, 16'd7);
        push(cdt_pkg::CMD_TICK, 16'h0001);
        push(cdt_pkg::CMD_RESET, 16'h0000);
        push(cdt_pkg::CMD_START, 16'hFFFF);
        push(cdt_pkg::CMD_TICK, 16'h8000);
        push(cdt_pkg::CMD_RESET, 16'hFFFF);
    endfunction

    function automatic void load_directed_up();
        push(cdt_pkg::CMD_START, 16'hFFFF);
        push(cdt_pkg::CMD_TICK, 16'h0000);
        push(cdt_pkg::CMD_PAUSE, 16'h1234);
        push(cdt_pkg::CMD_TICK, 16'hFFFF);
        push(cdt_pkg::CMD_START, 16'h0000);  // resume without reload
        push(cdt_pkg::CMD_RESET, 16'h0000);
        push(cdt_pkg::CMD_START, 16'h0000);  // count-up with nothing loaded still ticks
        push(cdt_pkg::CMD_TICK, 16'hEDCB);
        push(cdt_pkg::CMD_START, 16'd9);
    endfunction

    // start sequences followed by tick bursts, with pauses and resets mixed in
    function automatic void load_random(int n);
        int r;
        int burst;
        int k;
        while (stim_q.size() < n) begin
            if ($urandom_range(0, 1)) begin
                push(cdt_pkg::CMD_RESET, any_secs());
            end
            push(cdt_pkg::CMD_START, start_secs());
            r = $urandom_range(0, 99);
            burst = (r < 70) ? $urandom_range(1, 40) :
                    (r < 95) ? $urandom_range(60, 160) : $urandom_range(200, 320);
            for (k = 0; k < burst && stim_q.size() < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    push(cdt_pkg::CMD_PAUSE, any_secs());
                end else if (r < 6) begin
                    push(cdt_pkg::CMD_START, start_secs());
                end else if (r < 7) begin
                    push(cdt_pkg::CMD_RESET, any_secs());
                end else begin
                    push(cdt_pkg::CMD_TICK, any_secs());
                end
            end
        end
    endfunction

    task automatic write_mode(bit m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        tracker.set_mode(m);
        cfg_we    <= 1'b0;
    endtask

    task automatic drive_items();
        int gap;
        while (stim_q.size() > 0) begin
            gap = pick_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_valid <= 1'b1;
            in_data  <= stim_q[0];
            do begin
                @(posedge i_clk);
            end while (!(in_valid && !in_stall));
            tracker.note_command(stim_q.pop_front());
        end
        in_valid <= 1'b0;
    endtask

    task automatic run_phase();
        quiet = ($urandom_range(0, 3) == 0);
        drive_items();
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_side
        int run_left;
        bit hold;
        run_left = 0;
        hold     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                tracker.check_reading(out_data);
            end
            if (run_left == 0) begin
                hold     = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
                run_left = hold ? pick_gap() + 1 : $urandom_range(1, 12);
            end
            run_left--;
            out_stall <= hold;
        end
    end

    initial begin : main_seq
        int sent;
        int batch;
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);
        load_directed_down();
        run_phase();
        write_mode(1'b1);
        load_directed_up();
        run_phase();
        sent = 0;
        while (sent < 800) begin
            write_mode(1'($urandom_range(0, 1)));
            batch = $urandom_range(80, 200);
            if (batch > 800 - sent) begin
                batch = 800 - sent;
            end
            load_random(batch);
            sent += stim_q.size();
            run_phase();
        end
        // catch any stray transaction after the last expected one
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("countdown_timer_with_progress_core_tb: PASS");
        end else begin
            $display("countdown_timer_with_progress_core_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("countdown_timer_with_progress_core_tb: FAIL");
        $finish;
    end

endmodule
